### design/hbkv_pkg.sv
`timescale 1ns / 1ps

package hbkv_pkg;

	localparam int SLOTS_DEF      = 64;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	localparam int CAP_W   = 7;
	localparam int SLOT_W  = 6;
	localparam int COUNT_W = 7;
	localparam int OP_W    = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP  = 3'd0,
		OP_INSERT  = 3'd1,
		OP_REM_KEY = 3'd2,
		OP_REM_AT  = 3'd3,
		OP_READ    = 3'd4,
		OP_CLEAR   = 3'd5
	} op_t;

	// Completion status from the sequencer to the result stage
	typedef struct packed {
		logic               done;
		logic               ok;
		logic [COUNT_W-1:0] entry_count;
		logic               is_full;
		logic               is_empty;
	} status_t;

endpackage

### design/hbkv_req_if.sv
`timescale 1ns / 1ps

interface hbkv_req_if #(
	parameter int KEY_BITS   = hbkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = hbkv_pkg::VALUE_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic [hbkv_pkg::OP_W-1:0]    operation;
	logic [KEY_BITS-1:0]          key;
	logic [VALUE_BITS-1:0]        value;
	logic [hbkv_pkg::SLOT_W-1:0]  slot;

	modport source (output valid, output operation, output key, output value, output slot,
		input ready);
	modport sink (input valid, input operation, input key, input value, input slot,
		output ready);
endinterface

interface hbkv_rsp_if #(
	parameter int KEY_BITS   = hbkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = hbkv_pkg::VALUE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic [VALUE_BITS-1:0]         found_value;
	logic [KEY_BITS-1:0]           found_key;
	logic [hbkv_pkg::COUNT_W-1:0]  entry_count;
	logic                          is_full;
	logic                          is_empty;

	modport source (output valid, output ok, output found_value, output found_key,
		output entry_count, output is_full, output is_empty, input ready);
	modport sink (input valid, input ok, input found_value, input found_key,
		input entry_count, input is_full, input is_empty, output ready);
endinterface

### design/hbkv_ram.sv
`timescale 1ns / 1ps

module hbkv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/hbkv_ctrl.sv
`timescale 1ns / 1ps

module hbkv_ctrl #(
	parameter int SLOTS      = hbkv_pkg::SLOTS_DEF,
	parameter int KEY_BITS   = hbkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = hbkv_pkg::VALUE_BITS_DEF,
	localparam int ADDR_W = $clog2(SLOTS),
	localparam int CNT_W  = $clog2(SLOTS + 1),
	localparam int ENT_W  = KEY_BITS + VALUE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [hbkv_pkg::OP_W-1:0]    op,
	input  logic [KEY_BITS-1:0]          key,
	input  logic [VALUE_BITS-1:0]        value,
	input  logic [hbkv_pkg::SLOT_W-1:0]  slot,
	input  logic [hbkv_pkg::CAP_W-1:0]   cap,
	input  logic                         take,
	output logic                         ready,
	output hbkv_pkg::status_t            stat,
	output logic [KEY_BITS-1:0]          fkey,
	output logic [VALUE_BITS-1:0]        fval,
	output logic                         ram_we,
	output logic [ADDR_W-1:0]            ram_waddr,
	output logic [ENT_W-1:0]             ram_wdata,
	output logic [ADDR_W-1:0]            ram_raddr,
	input  logic [ENT_W-1:0]             ram_rdata
);

	localparam int CMP_W = (CNT_W > hbkv_pkg::CAP_W) ? CNT_W : hbkv_pkg::CAP_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_READ,
		S_RWAIT,
		S_DONE
	} state_t;

	state_t                 state_q;
	hbkv_pkg::op_t          op_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [VALUE_BITS-1:0]  val_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       rd_addr_q;
	logic [ADDR_W-1:0]      cmp_idx_s1;
	logic                   cmp_vld_s1;
	logic                   ok_q;
	logic [KEY_BITS-1:0]    fkey_q;
	logic [VALUE_BITS-1:0]  fval_q;

	logic [CMP_W-1:0]       cap_e;
	logic [CMP_W-1:0]       eff_cap;
	logic                   full;
	logic                   slot_lt;
	logic                   match;
	logic                   more;
	logic                   ins_hit;
	logic [KEY_BITS-1:0]    rd_key;
	logic [VALUE_BITS-1:0]  rd_val;
	logic [ADDR_W-1:0]      idx_dec;

	assign rd_key  = ram_rdata[ENT_W-1:VALUE_BITS];
	assign rd_val  = ram_rdata[VALUE_BITS-1:0];
	assign cap_e   = CMP_W'(cap);
	assign eff_cap = (cap_e > CMP_W'(SLOTS)) ? CMP_W'(SLOTS) : cap_e;
	assign full    = CMP_W'(count_q) >= eff_cap;
	assign slot_lt = CMP_W'(slot) < CMP_W'(count_q);
	assign match   = cmp_vld_s1 && (rd_key == key_q);
	assign more    = rd_addr_q < count_q;
	assign idx_dec = cmp_idx_s1 - ADDR_W'(1);
	// scan over without a match: the insert lands at slot count
	assign ins_hit = (state_q == S_SCAN) && (op_q == hbkv_pkg::OP_INSERT) && !match && !more;

	assign ram_raddr = rd_addr_q[ADDR_W-1:0];
	assign ram_we    = ins_hit || ((state_q == S_SHIFT) && cmp_vld_s1);
	assign ram_waddr = (state_q == S_SHIFT) ? idx_dec : count_q[ADDR_W-1:0];
	assign ram_wdata = (state_q == S_SHIFT) ? ram_rdata : {key_q, val_q};

	assign ready = (state_q == S_IDLE);

	always_comb begin
		stat.done        = (state_q == S_DONE);
		stat.ok          = ok_q;
		stat.entry_count = hbkv_pkg::COUNT_W'(count_q);
		stat.is_full     = full;
		stat.is_empty    = (count_q == '0);
	end

	assign fkey = fkey_q;
	assign fval = fval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			op_q       <= hbkv_pkg::OP_LOOKUP;
			key_q      <= '0;
			val_q      <= '0;
			count_q    <= '0;
			rd_addr_q  <= '0;
			cmp_idx_s1 <= '0;
			cmp_vld_s1 <= 1'b0;
			ok_q       <= 1'b0;
			fkey_q     <= '0;
			fval_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q       <= hbkv_pkg::op_t'(op);
						key_q      <= key;
						val_q      <= value;
						ok_q       <= 1'b0;
						fkey_q     <= '0;
						fval_q     <= '0;
						rd_addr_q  <= '0;
						cmp_vld_s1 <= 1'b0;
						unique case (op)
							hbkv_pkg::OP_LOOKUP, hbkv_pkg::OP_REM_KEY: begin
								state_q <= S_SCAN;
							end
							hbkv_pkg::OP_INSERT: begin
								state_q <= full ? S_DONE : S_SCAN;
							end
							hbkv_pkg::OP_REM_AT: begin
								if (slot_lt) begin
									rd_addr_q <= CNT_W'(CMP_W'(slot) + CMP_W'(1));
									ok_q      <= 1'b1;
									state_q   <= S_SHIFT;
								end else begin
									state_q <= S_DONE;
								end
							end
							hbkv_pkg::OP_READ: begin
								if (slot_lt) begin
									rd_addr_q <= CNT_W'(slot);
									state_q   <= S_READ;
								end else begin
									state_q <= S_DONE;
								end
							end
							hbkv_pkg::OP_CLEAR: begin
								count_q <= '0;
								ok_q    <= 1'b1;
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (match) begin
						cmp_vld_s1 <= 1'b0;
						priority case (op_q)
							hbkv_pkg::OP_LOOKUP: begin
								ok_q    <= 1'b1;
								fval_q  <= rd_val;
								state_q <= S_DONE;
							end
							hbkv_pkg::OP_REM_KEY: begin
								ok_q      <= 1'b1;
								rd_addr_q <= CNT_W'(cmp_idx_s1) + CNT_W'(1);
								state_q   <= S_SHIFT;
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end else if (more) begin
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= rd_addr_q[ADDR_W-1:0];
						rd_addr_q  <= rd_addr_q + CNT_W'(1);
					end else begin
						cmp_vld_s1 <= 1'b0;
						if (op_q == hbkv_pkg::OP_INSERT) begin
							count_q <= count_q + CNT_W'(1);
							ok_q    <= 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_SHIFT: begin
					if (more) begin
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= rd_addr_q[ADDR_W-1:0];
						rd_addr_q  <= rd_addr_q + CNT_W'(1);
					end else begin
						cmp_vld_s1 <= 1'b0;
						count_q    <= count_q - CNT_W'(1);
						state_q    <= S_DONE;
					end
				end
				S_READ: begin
					state_q <= S_RWAIT;
				end
				S_RWAIT: begin
					fkey_q  <= rd_key;
					fval_q  <= rd_val;
					ok_q    <= 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("entry count above slot count");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && cmp_vld_s1) |-> (cmp_idx_s1 != '0 && CNT_W'(cmp_idx_s1) < count_q))
		else $error("shift write outside occupied slots");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !take) |=> (state_q == S_DONE && $stable(count_q)))
		else $error("finished result not held while stalled");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		ins_hit |-> (count_q < CNT_W'(SLOTS)))
		else $error("insert into a full slot array");
`endif

endmodule

### design/hash_bucket_key_value_store.sv
`timescale 1ns / 1ps

// Key/value bucket: up to SLOTS pairs packed in slots 0..count-1 of one slot memory, with
// a capacity register (cfg_we/cfg_wdata, reset 64, clipped to SLOTS). Each request
// transaction carries an operation (lookup, insert, remove by key, remove at slot, read
// slot, clear) and returns exactly one response transaction with ok, the value and/or key
// found, the entry count and full/empty flags after the operation. One request is worked
// at a time; req.ready is high only while the sequencer is idle. The slot memory has one
// read and one write port and is walked one slot per cycle; remove by key scans to the hit,
// then shifts the tail down. A finished response sits in the output register until
// taken, and the next request is accepted meanwhile. Write the capacity only while no
// transaction is in flight.
module hash_bucket_key_value_store #(
	parameter int SLOTS      = hbkv_pkg::SLOTS_DEF,
	parameter int KEY_BITS   = hbkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = hbkv_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [hbkv_pkg::CAP_W-1:0]  cfg_wdata,
	hbkv_req_if.sink                    req,
	hbkv_rsp_if.source                  rsp
);

	localparam int ADDR_W = $clog2(SLOTS);
	localparam int ENT_W  = KEY_BITS + VALUE_BITS;

	logic [hbkv_pkg::CAP_W-1:0]  cap_q;

	logic                        start;
	logic                        take;
	logic                        ctrl_ready;
	hbkv_pkg::status_t           stat;
	logic [KEY_BITS-1:0]         fkey;
	logic [VALUE_BITS-1:0]       fval;

	logic                        ram_we;
	logic [ADDR_W-1:0]           ram_waddr;
	logic [ENT_W-1:0]            ram_wdata;
	logic [ADDR_W-1:0]           ram_raddr;
	logic [ENT_W-1:0]            ram_rdata;

	logic                        rsp_valid_q;
	logic                        ok_q;
	logic [VALUE_BITS-1:0]       found_value_q;
	logic [KEY_BITS-1:0]         found_key_q;
	logic [hbkv_pkg::COUNT_W-1:0] entry_count_q;
	logic                        is_full_q;
	logic                        is_empty_q;

	// Capacity register: write whenever enabled, no read-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= hbkv_pkg::CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	assign req.ready = ctrl_ready;
	assign start     = req.valid && ctrl_ready;

	// The output register can take a new response when empty or being drained
	assign take = !rsp_valid_q || rsp.ready;

	// Slot memory: key in the upper bits, value in the lower bits of each entry
	hbkv_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer: scan, shift and read the slots through the single memory port pair
	hbkv_ctrl #(
		.SLOTS      (SLOTS),
		.KEY_BITS   (KEY_BITS),
		.VALUE_BITS (VALUE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (req.operation),
		.key       (req.key),
		.value     (req.value),
		.slot      (req.slot),
		.cap       (cap_q),
		.take      (take),
		.ready     (ctrl_ready),
		.stat      (stat),
		.fkey      (fkey),
		.fval      (fval),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Response register: load a finished result, hold it while stalled, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (stat.done && take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done && take) begin
			ok_q          <= stat.ok;
			found_value_q <= fval;
			found_key_q   <= fkey;
			entry_count_q <= stat.entry_count;
			is_full_q     <= stat.is_full;
			is_empty_q    <= stat.is_empty;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.ok          = ok_q;
	assign rsp.found_value = found_value_q;
	assign rsp.found_key   = found_key_q;
	assign rsp.entry_count = entry_count_q;
	assign rsp.is_full     = is_full_q;
	assign rsp.is_empty    = is_empty_q;

endmodule
